FILE: src/utf8fap_pkg.sv
package utf8fap_pkg;

	// Field and port widths
	localparam int BYTE_W   = 8;
	localparam int AMOUNT_W = 40;
	localparam int MIN_W    = 4;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;
	localparam int CP_W     = 16;

	// Digit limit and the counter that saturates one above it
	localparam int MAX_DIGITS = 12;
	localparam int TOTAL_W    = $clog2(MAX_DIGITS + 2);

	// Register map, by word index
	localparam logic [ADDR_W-3:0] REG_MIN_DIGITS = '0;
	localparam logic [MIN_W-1:0]  MIN_DIGITS_RESET = 4'd3;

	// Lead byte classes
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
	localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;
	localparam logic [BYTE_W-1:0] ASCII_TOP  = 8'h80;

	// Code points that fold
	localparam logic [CP_W-1:0] CP_FOLD_LO    = 16'hFF01;
	localparam logic [CP_W-1:0] CP_FOLD_HI    = 16'hFF5E;
	localparam logic [CP_W-1:0] CP_FOLD_OFS   = 16'hFEE0;
	localparam logic [CP_W-1:0] CP_LONG_VOWEL = 16'h30FC;
	localparam logic [CP_W-1:0] CP_MINUS      = 16'h2212;
	localparam logic [CP_W-1:0] CP_HYPHEN     = 16'h2010;

	// ASCII characters of interest
	localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_HYPHEN = 8'h2D;

	// Group decoder phase
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LEAD,
		PH_SECOND
	} phase_t;

	// Up to two characters that can matter, in stream order
	typedef struct packed {
		logic              c0_valid;
		logic [BYTE_W-1:0] c0;
		logic              c1_valid;
		logic [BYTE_W-1:0] c1;
	} char_pair_t;

	// Result register contents
	typedef struct packed {
		logic                valid;
		logic [AMOUNT_W-1:0] amount;
		logic                amount_valid;
	} result_t;

endpackage

FILE: src/utf8fap_in_if.sv
interface utf8fap_in_if import utf8fap_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              last_byte;

	modport source (output valid, output in_byte, output last_byte, input ready);
	modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

FILE: src/utf8fap_out_if.sv
interface utf8fap_out_if import utf8fap_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [AMOUNT_W-1:0] amount;
	logic                amount_valid;

	modport source (output valid, output amount, output amount_valid, input ready);
	modport sink (input valid, input amount, input amount_valid, output ready);
endinterface

FILE: src/utf8fap_cfg.sv
module utf8fap_cfg import utf8fap_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [MIN_W-1:0]  min_digits
);

	logic [MIN_W-1:0]  min_digits_q;
	logic [ADDR_W-3:0] word_idx;
	logic              wr_en;

	assign pready   = 1'b1;
	assign word_idx = paddr[ADDR_W-1:2];
	assign wr_en    = psel && penable && pwrite && pready;

	// Write the register in the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_digits_q <= MIN_DIGITS_RESET;
		end else if (wr_en && word_idx == REG_MIN_DIGITS) begin
			min_digits_q <= pwdata[MIN_W-1:0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (word_idx == REG_MIN_DIGITS) begin
			prdata = DATA_W'(min_digits_q);
		end
	end

	assign min_digits = min_digits_q;

endmodule

FILE: src/utf8fap_decode.sv
module utf8fap_decode import utf8fap_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] byte_s1,
	input  logic              last_s1,
	output char_pair_t        chars
);

	logic [1:0]        raw_left_q, raw_left_d;
	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] lead_q, lead_d;
	logic [BYTE_W-1:0] second_q, second_d;

	logic [BYTE_W-1:0] lead_lo, second_lo, byte_lo;
	logic [CP_W-1:0]   cp;
	logic [CP_W-1:0]   cp_fold;
	logic              is_lead3, is_lead2;

	assign lead_lo   = lead_q & LEAD3_BITS;
	assign second_lo = second_q & CONT_BITS;
	assign byte_lo   = byte_s1 & CONT_BITS;
	assign cp        = {lead_lo[3:0], second_lo[5:0], byte_lo[5:0]};
	assign cp_fold   = cp - CP_FOLD_OFS;
	assign is_lead3  = (byte_s1 & LEAD3_MASK) == LEAD3_CODE;
	assign is_lead2  = (byte_s1 & LEAD2_MASK) == LEAD2_CODE;

	// Next group state
	always_comb begin
		raw_left_d = raw_left_q;
		phase_d    = phase_q;
		lead_d     = lead_q;
		second_d   = second_q;
		if (raw_left_q != 2'd0) begin
			raw_left_d = raw_left_q - 2'd1;
		end else begin
			case (phase_q)
				PH_LEAD: begin
					second_d = byte_s1;
					phase_d  = PH_SECOND;
				end
				PH_SECOND: begin
					phase_d = PH_IDLE;
				end
				default: begin
					if (byte_s1 < ASCII_TOP) begin
						raw_left_d = 2'd0;
					end else if (is_lead3) begin
						lead_d  = byte_s1;
						phase_d = PH_LEAD;
					end else if (is_lead2) begin
						raw_left_d = 2'd1;
					end else begin
						raw_left_d = 2'd3;
					end
				end
			endcase
		end
		// End of field: drop any open group
		if (last_s1) begin
			raw_left_d = 2'd0;
			phase_d    = PH_IDLE;
			lead_d     = '0;
			second_d   = '0;
		end
	end

	// Characters passed on; a held lead byte never counts, so it is left out
	always_comb begin
		chars = '0;
		if (raw_left_q != 2'd0) begin
			chars.c0_valid = 1'b1;
			chars.c0       = byte_s1;
		end else begin
			case (phase_q)
				PH_LEAD: begin
					// Group cut short: flush the second byte raw
					chars.c0_valid = last_s1;
					chars.c0       = byte_s1;
				end
				PH_SECOND: begin
					if (cp >= CP_FOLD_LO && cp <= CP_FOLD_HI) begin
						chars.c0_valid = 1'b1;
						chars.c0       = cp_fold[BYTE_W-1:0];
					end else if (cp == CP_LONG_VOWEL || cp == CP_MINUS || cp == CP_HYPHEN) begin
						chars.c0_valid = 1'b1;
						chars.c0       = CHAR_HYPHEN;
					end else begin
						chars.c0_valid = 1'b1;
						chars.c0       = second_q;
						chars.c1_valid = 1'b1;
						chars.c1       = byte_s1;
					end
				end
				default: begin
					chars.c0_valid = !is_lead3;
					chars.c0       = byte_s1;
				end
			endcase
		end
	end

	// Group state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_left_q <= 2'd0;
			phase_q    <= PH_IDLE;
			lead_q     <= '0;
			second_q   <= '0;
		end else if (step) begin
			raw_left_q <= raw_left_d;
			phase_q    <= phase_d;
			lead_q     <= lead_d;
			second_q   <= second_d;
		end
	end

endmodule

FILE: src/utf8fap_accum.sv
module utf8fap_accum import utf8fap_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             last_s1,
	input  char_pair_t       chars,
	input  logic [MIN_W-1:0] min_digits,
	input  logic             res_take,
	output result_t          res
);

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(MAX_DIGITS);

	typedef struct packed {
		logic               seen;
		logic               closed;
		logic [TOTAL_W-1:0] total;
		logic               accepted;
	} digit_state_t;

	function automatic digit_state_t take_char(input digit_state_t s, input logic v,
	                                           input logic [BYTE_W-1:0] c);
		digit_state_t r;
		r          = s;
		r.accepted = 1'b0;
		if (v && !s.closed) begin
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				r.seen = 1'b1;
				if (s.total <= TOTAL_MAX) begin
					r.total = s.total + 1'b1;
				end
				r.accepted = r.total <= TOTAL_MAX;
			end else if (c == CHAR_HYPHEN && s.seen) begin
				r.closed = 1'b1;
			end
		end
		return r;
	endfunction

	logic                seen_q, closed_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [AMOUNT_W-1:0] acc_q;
	digit_state_t        st0, st1, st2;
	logic [AMOUNT_W-1:0] acc10, acc100, acc_d;
	logic [7:0]          pair;
	logic                ok;
	logic                res_valid_q;
	logic [AMOUNT_W-1:0] res_amount_q;
	logic                res_ok_q;

	// Run the two characters through the digit rules in order
	always_comb begin
		st0 = '{seen: seen_q, closed: closed_q, total: total_q, accepted: 1'b0};
		st1 = take_char(st0, chars.c0_valid, chars.c0);
		st2 = take_char(st1, chars.c1_valid, chars.c1);
	end

	// Scale by ten or a hundred and add the digits taken
	assign acc10  = (acc_q << 3) + (acc_q << 1);
	assign acc100 = (acc_q << 6) + (acc_q << 5) + (acc_q << 2);
	assign pair   = (8'(chars.c0[3:0]) << 3) + (8'(chars.c0[3:0]) << 1) + 8'(chars.c1[3:0]);

	always_comb begin
		case ({st1.accepted, st2.accepted})
			2'b11:   acc_d = acc100 + AMOUNT_W'(pair);
			2'b10:   acc_d = acc10 + AMOUNT_W'(chars.c0[3:0]);
			2'b01:   acc_d = acc10 + AMOUNT_W'(chars.c1[3:0]);
			default: acc_d = acc_q;
		endcase
	end

	assign ok = (st2.total >= TOTAL_W'(1)) && (st2.total <= TOTAL_MAX)
	         && (8'(st2.total) >= 8'(min_digits));

	// Digit state: advance per byte, clear after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= 1'b0;
			closed_q <= 1'b0;
			total_q  <= '0;
			acc_q    <= '0;
		end else if (step) begin
			if (last_s1) begin
				seen_q   <= 1'b0;
				closed_q <= 1'b0;
				total_q  <= '0;
				acc_q    <= '0;
			end else begin
				seen_q   <= st2.seen;
				closed_q <= st2.closed;
				total_q  <= st2.total;
				acc_q    <= acc_d;
			end
		end
	end

	// Result register: load on the final byte, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (res_take) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			res_amount_q <= ok ? acc_d : '0;
			res_ok_q     <= ok;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.amount       = res_amount_q;
	assign res.amount_valid = res_ok_q;

endmodule

FILE: src/utf8_folding_amount_parser.sv
// The final byte passes through the input register, then the result register; the
// result is valid once the result register loads it, and out_ch.ready takes it.
// Throughput: one byte per cycle while the parser is not stalled, as the group
// decoder state and the digit accumulator update as each byte steps; a result not
// taken holds the next final byte in the input register and stalls input behind it.
// Reset: arst_n clears all group and digit state at once and sets min_digits to 3.
module utf8_folding_amount_parser import utf8fap_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	utf8fap_in_if.sink        in_ch,
	utf8fap_out_if.source     out_ch
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              out_free;
	logic              step;
	logic [MIN_W-1:0]  min_digits;
	char_pair_t        chars;
	result_t           res;

	// A final byte waits only until the result register is free
	assign out_free    = !res.valid || out_ch.ready;
	assign step        = valid_s1 && (!last_s1 || out_free);
	assign in_ch.ready = !valid_s1 || step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	utf8fap_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.min_digits(min_digits)
	);

	utf8fap_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.byte_s1(byte_s1),
		.last_s1(last_s1),
		.chars  (chars)
	);

	utf8fap_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.last_s1   (last_s1),
		.chars     (chars),
		.min_digits(min_digits),
		.res_take  (out_ch.ready),
		.res       (res)
	);

	assign out_ch.valid        = res.valid;
	assign out_ch.amount       = res.amount;
	assign out_ch.amount_valid = res.amount_valid;

endmodule

FILE: dv/utf8_folding_amount_parser_tb.sv
module utf8_folding_amount_parser_tb;
	import utf8fap_pkg::*;

	// One byte of a text field as it is sent
	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              last;
	} field_byte_t;

	// One expected amount result
	typedef struct {
		logic [AMOUNT_W-1:0] amount;
		logic                ok;
	} amount_exp_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	utf8fap_in_if  in_ch ();
	utf8fap_out_if out_ch ();

	utf8_folding_amount_parser uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	field_byte_t field_bytes[$];
	amount_exp_t expected_amounts[$];
	int          mismatch_count = 0;
	int          in_calm = 0;
	int          out_calm = 0;

	// Parser mirror: group decoder, digit collector, threshold
	logic [MIN_W-1:0]  min_digits_cfg;
	int                raw_rest;
	phase_t            grp_phase;
	logic [BYTE_W-1:0] grp_lead;
	logic [BYTE_W-1:0] grp_second;
	logic              saw_digit;
	logic              num_closed;
	int                digit_cnt;
	logic [63:0]       amt_acc;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 500000);
		$display("utf8_folding_amount_parser_tb NOT OK");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Draw a per-item wait, with occasional runs of back-to-back items
	task automatic draw_gap(inout int calm, output int gap);
		if (calm > 0) begin
			calm--;
			gap = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 30);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 6);
		end
	endtask

	task automatic clear_parse();
		raw_rest = 0;
		grp_phase = PH_IDLE;
		grp_lead = '0;
		grp_second = '0;
		saw_digit = 1'b0;
		num_closed = 1'b0;
		digit_cnt = 0;
		amt_acc = '0;
	endtask

	// Feed one character to the digit collector
	task automatic collect_char(input logic [BYTE_W-1:0] c);
		if (num_closed)
			return;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			saw_digit = 1'b1;
			if (digit_cnt <= MAX_DIGITS)
				digit_cnt++;
			if (digit_cnt <= MAX_DIGITS)
				amt_acc = amt_acc * 10 + 64'(c - CHAR_ZERO);
		end else if (c == CHAR_HYPHEN && saw_digit) begin
			num_closed = 1'b1;
		end
	endtask

	// Advance the mirror by one accepted byte; queue the amount on the final byte
	task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic last);
		logic [CP_W-1:0] cp;
		logic [CP_W-1:0] folded;
		amount_exp_t     e;
		if (raw_rest > 0) begin
			collect_char(b);
			raw_rest--;
		end else if (grp_phase == PH_LEAD) begin
			grp_second = b;
			grp_phase = PH_SECOND;
			if (last) begin
				collect_char(grp_lead);
				collect_char(grp_second);
			end
		end else if (grp_phase == PH_SECOND) begin
			cp = {grp_lead[3:0], grp_second[5:0], b[5:0]};
			if (cp >= CP_FOLD_LO && cp <= CP_FOLD_HI) begin
				folded = cp - CP_FOLD_OFS;
				collect_char(folded[BYTE_W-1:0]);
			end else if (cp == CP_LONG_VOWEL || cp == CP_MINUS || cp == CP_HYPHEN) begin
				collect_char(CHAR_HYPHEN);
			end else begin
				collect_char(grp_lead);
				collect_char(grp_second);
				collect_char(b);
			end
			grp_phase = PH_IDLE;
		end else if (b < ASCII_TOP) begin
			collect_char(b);
		end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
			grp_lead = b;
			grp_phase = PH_LEAD;
			if (last)
				collect_char(b);
		end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
			collect_char(b);
			raw_rest = 1;
		end else begin
			collect_char(b);
			raw_rest = 3;
		end
		if (last) begin
			e.ok = digit_cnt >= 1 && digit_cnt <= MAX_DIGITS && digit_cnt >= min_digits_cfg;
			e.amount = e.ok ? amt_acc[AMOUNT_W-1:0] : '0;
			expected_amounts.insert(expected_amounts.size(), e);
			clear_parse();
		end
	endtask

	// Compare each accepted result with the oldest expected amount
	always @(posedge clk) begin
		amount_exp_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_amounts.size() == 0) begin
				report_mismatch($sformatf("unexpected result amount=%0d valid=%0b",
					out_ch.amount, out_ch.amount_valid));
			end else begin
				e = expected_amounts.pop_front();
				if (out_ch.amount !== e.amount)
					report_mismatch($sformatf("amount %0d, expected %0d",
						out_ch.amount, e.amount));
				if (out_ch.amount_valid !== e.ok)
					report_mismatch($sformatf("amount_valid %0b, expected %0b",
						out_ch.amount_valid, e.ok));
			end
		end
	end

	// Result side: stall a random number of cycles before taking each item
	initial begin : result_sink
		int gap;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			draw_gap(out_calm, gap);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	task automatic push_byte(input logic [BYTE_W-1:0] b);
		field_byte_t f;
		f.data = b;
		f.last = 1'b0;
		field_bytes.insert(field_bytes.size(), f);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	// Encode a code point as a three-byte group
	task automatic push_cp3(input logic [CP_W-1:0] cp);
		push_byte({4'hE, cp[15:12]});
		push_byte({2'b10, cp[11:6]});
		push_byte({2'b10, cp[5:0]});
	endtask

	task automatic end_field();
		field_bytes[field_bytes.size() - 1].last = 1'b1;
	endtask

	// Send every queued byte, predicting each on acceptance
	task automatic send_fields();
		field_byte_t f;
		int          gap;
		while (field_bytes.size() > 0) begin
			f = field_bytes.pop_front();
			draw_gap(in_calm, gap);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_ch.valid <= 1'b1;
			in_ch.in_byte <= f.data;
			in_ch.last_byte <= f.last;
			do @(posedge clk); while (!in_ch.ready);
			predict_byte(f.data, f.last);
		end
		in_ch.valid <= 1'b0;
	endtask

	// Hold until every expected amount is out and the pipeline is empty
	task automatic drain_results();
		while (expected_amounts.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_min_digits(input logic [MIN_W-1:0] v);
		logic [DATA_W-1:0] w;
		w = $urandom;
		w[MIN_W-1:0] = v;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_MIN_DIGITS, 2'b00};
		pwdata <= w;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		min_digits_cfg = v;
		@(posedge clk);
	endtask

	// Folding, separators, raw groups and cut-short groups at the reset threshold
	task automatic test_folding_directed();
		// digits, full-width three, minus sign closes
		push_text("12");
		push_cp3(16'hFF13);
		push_cp3(CP_MINUS);
		push_text("5");
		end_field();
		// two-byte lead and top byte each carry raw bytes, hyphen closes
		push_text("0");
		push_byte(8'hC3);
		push_text("9");
		push_byte(8'hFF);
		push_text("123");
		push_cp3(CP_HYPHEN);
		end_field();
		// ASCII inside a group, zero byte, lone lead cut by the end
		push_byte(8'hE3);
		push_text("12");
		push_byte(8'h00);
		push_text("5");
		push_byte(8'hE5);
		end_field();
		// lead and second byte cut by the end
		push_text("7");
		push_byte(8'hE9);
		push_text("8");
		end_field();
		// leading long vowel ignored, full-width hyphen closes, stray byte cut
		push_cp3(CP_LONG_VOWEL);
		push_text("456");
		push_cp3(16'hFF0D);
		push_byte(8'h8F);
		end_field();
		send_fields();
		drain_results();
	endtask

	// Threshold extremes: none, the digit limit, and above the limit
	task automatic test_threshold_extremes();
		write_min_digits(4'd0);
		push_text("x");
		end_field();
		push_text("0");
		end_field();
		send_fields();
		drain_results();
		write_min_digits(4'(MAX_DIGITS));
		for (int i = 0; i < MAX_DIGITS; i++)
			push_text("9");
		end_field();
		for (int i = 0; i <= MAX_DIGITS; i++)
			push_text("9");
		end_field();
		send_fields();
		drain_results();
		write_min_digits(4'd15);
		push_text("123");
		end_field();
		send_fields();
		drain_results();
	endtask

	// Add one token of a random field, mostly well-formed characters
	task automatic push_random_token();
		logic [CP_W-1:0] cp;
		case ($urandom_range(0, 19))
			7, 8, 9: push_cp3(16'hFF10 + CP_W'($urandom_range(0, 9)));
			10: push_cp3(CP_W'($urandom_range(16'hFF01, 16'hFF5E)));
			11: begin
				case ($urandom_range(0, 4))
					0: push_byte(CHAR_HYPHEN);
					1: push_cp3(CP_LONG_VOWEL);
					2: push_cp3(CP_MINUS);
					3: push_cp3(CP_HYPHEN);
					default: push_cp3(16'hFF0D);
				endcase
			end
			12: push_byte(BYTE_W'($urandom_range(0, 127)));
			13: begin
				push_byte(BYTE_W'($urandom_range(8'hC0, 8'hDF)));
				push_byte(BYTE_W'($urandom_range(0, 255)));
			end
			14: begin
				if ($urandom_range(0, 1))
					push_byte(BYTE_W'($urandom_range(8'hF0, 8'hFF)));
				else
					push_byte(BYTE_W'($urandom_range(8'h80, 8'hBF)));
				repeat (3) push_byte(BYTE_W'($urandom_range(0, 255)));
			end
			15: begin
				push_byte(BYTE_W'($urandom_range(8'hE0, 8'hEF)));
				repeat (2) push_byte(BYTE_W'($urandom_range(0, 255)));
			end
			16: push_byte(BYTE_W'($urandom_range(0, 255)));
			17: begin
				// code points just outside the folded and separator sets
				case ($urandom_range(0, 3))
					0: cp = 16'hFF00;
					1: cp = 16'hFF5F;
					2: cp = CP_LONG_VOWEL + 1;
					default: cp = CP_HYPHEN - 1;
				endcase
				push_cp3(cp);
			end
			default: push_byte(CHAR_ZERO + BYTE_W'($urandom_range(0, 9)));
		endcase
	endtask

	task automatic push_random_field();
		int tokens;
		tokens = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
		repeat (tokens) push_random_token();
		// sometimes end inside a group or a raw run
		case ($urandom_range(0, 7))
			0: push_byte(BYTE_W'($urandom_range(8'hE0, 8'hEF)));
			1: begin
				push_byte(BYTE_W'($urandom_range(8'hE0, 8'hEF)));
				push_byte(BYTE_W'($urandom_range(0, 255)));
			end
			2: push_byte(BYTE_W'($urandom_range(8'h80, 8'hFF)));
			default: ;
		endcase
		end_field();
	endtask

	// Random fields over several threshold settings
	task automatic test_random_fields();
		logic [MIN_W-1:0] settings[6];
		int               sent;
		settings = '{4'd0, 4'd12, 4'd15, 4'd1, 4'd3, 4'd3};
		settings[4] = MIN_W'($urandom_range(0, 15));
		settings[5] = MIN_W'($urandom_range(0, 15));
		foreach (settings[p]) begin
			write_min_digits(settings[p]);
			sent = 0;
			while (sent < 125) begin
				push_random_field();
				sent = field_bytes.size();
			end
			send_fields();
			drain_results();
		end
	endtask

	initial begin : main
		int waited;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.in_byte <= '0;
		in_ch.last_byte <= 1'b0;
		min_digits_cfg = MIN_DIGITS_RESET;
		clear_parse();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_folding_directed();
		test_threshold_extremes();
		test_random_fields();

		// Wait out the tail with a limit
		waited = 0;
		while (expected_amounts.size() > 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (expected_amounts.size() > 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				expected_amounts.size()));
		if (mismatch_count == 0)
			$display("utf8_folding_amount_parser_tb OK");
		else
			$display("utf8_folding_amount_parser_tb NOT OK");
		$finish;
	end

endmodule
